FILE: sv/cfs_pkg.sv
// ----------------------------------------------------------------------------
// cfs_pkg
// Shared types and constants for the CSV field splitter.
// ----------------------------------------------------------------------------
package cfs_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DELIMITER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUOTE     = 1'b1;

  localparam logic [7:0] DELIMITER_RESET = 8'd44;  // ','
  localparam logic [7:0] QUOTE_RESET     = 8'd34;  // '"'

  // whitespace bytes
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;

  // result kinds
  localparam logic [1:0] OK_CHAR      = 2'd0;
  localparam logic [1:0] OK_FIELD_END = 2'd1;
  localparam logic [1:0] OK_LINE_END  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FL_READ,
    ST_FL_EMIT,
    ST_FL_LAST
  } state_t;

  // class of an incoming item, in decode priority order
  typedef enum logic [2:0] {
    CLS_EOL,
    CLS_QUOTE,
    CLS_DELIM,
    CLS_SPACE,
    CLS_CHAR
  } cls_t;

  // output register source select
  typedef enum logic [2:0] {
    OSEL_EOL,
    OSEL_DELIM,
    OSEL_BYTE,
    OSEL_PEND,
    OSEL_HELD
  } osel_t;

  typedef struct packed {
    logic  accept;
    logic  load_out;
    osel_t osel;
    logic  last;
    logic  idx_inc;
    logic  flush_done;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic held_empty;
    logic idx_last;
    logic out_free;
  } status_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

FILE: sv/csv_field_splitter_unit.sv
// ----------------------------------------------------------------------------
// csv_field_splitter_unit
// Splits a stream of text lines into fields, one result item per character.
// ----------------------------------------------------------------------------
// Each input item is a text byte (tuser = 0) or an end-of-line mark
// (tuser = 1). Output items carry field characters, field ends and line ends
// together with the field index within the line (saturating at 255) and a
// flag set once trailing whitespace overflowed the hold buffer in that field.
// tlast marks the last output item caused by one input item. The quote byte
// toggles quoted mode and is dropped; the delimiter outside quotes ends a
// field; leading whitespace is dropped and trailing whitespace is held (up to
// HOLD_DEPTH bytes) until a later non-whitespace byte releases it. If the
// quote and delimiter bytes are equal, the byte acts as a quote.
// Throughput: one input item per cycle while the receiver keeps up, except a
// non-whitespace byte that releases held whitespace bytes: the block accepts
// it, then for each held byte has a read state for the hold RAM's single
// registered read port and an output state, and last outputs the byte itself,
// taking no new input meanwhile. An input item is taken only when the output
// register is empty or its result leaves in that same cycle, so a stalled
// receiver stalls the input, dropped bytes included. The hold RAM needs no
// clearing after reset; the block is ready straight out of reset.
// Configuration writes are to be made only while the block is idle.
// ----------------------------------------------------------------------------
module csv_field_splitter_unit #(
  parameter int HOLD_DEPTH = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_we,
  input  logic [cfs_pkg::CFG_IDX_W-1:0] cfg_index,    // 0 delimiter, 1 quote
  input  logic [7:0]                    cfg_data,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] byte_in
  input  logic [0:0]                    s_axis_tuser,  // [0] kind
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,  // [7:0] char_out, [15:8] field_number
  output logic [2:0]                    m_axis_tuser,  // [1:0] out_kind, [2] ws_overflow
  output logic                          m_axis_tlast   // last item of this input's run
);
  import cfs_pkg::*;

  cmd_t       cmd;
  status_t    status;
  logic [1:0] out_kind;
  logic [7:0] out_char;
  logic [7:0] out_field;
  logic       out_ovf;

  cfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cfs_dp #(.HOLD_DEPTH(HOLD_DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_kind   (s_axis_tuser[0]),
    .in_byte   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_kind  (out_kind),
    .out_char  (out_char),
    .out_field (out_field),
    .out_ovf   (out_ovf),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_field, out_char};
  assign m_axis_tuser = {out_ovf, out_kind};

endmodule

FILE: sv/cfs_ram.sv
// ----------------------------------------------------------------------------
// cfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/cfs_ctrl.sv
// ----------------------------------------------------------------------------
// cfs_ctrl
// Sequencer: accepts items and walks the held whitespace flush.
// ----------------------------------------------------------------------------
module cfs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  cfs_pkg::status_t status,
  output cfs_pkg::cmd_t    cmd
);
  import cfs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd.accept     = 1'b0;
    cmd.load_out   = 1'b0;
    cmd.osel       = OSEL_BYTE;
    cmd.last       = 1'b1;
    cmd.idx_inc    = 1'b0;
    cmd.flush_done = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = status.out_free;
        if (in_valid && status.out_free) begin
          cmd.accept = 1'b1;
          case (status.cls)
            CLS_EOL: begin
              cmd.load_out = 1'b1;
              cmd.osel     = OSEL_EOL;
            end
            CLS_DELIM: begin
              cmd.load_out = 1'b1;
              cmd.osel     = OSEL_DELIM;
            end
            CLS_CHAR: begin
              if (status.held_empty) begin
                cmd.load_out = 1'b1;
                cmd.osel     = OSEL_BYTE;
              end else begin
                state_next = ST_FL_READ;
              end
            end
            default: ;
          endcase
        end
      end
      // hold RAM read latency
      ST_FL_READ: begin
        state_next = ST_FL_EMIT;
      end
      ST_FL_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          cmd.osel     = OSEL_HELD;
          cmd.last     = 1'b0;
          cmd.idx_inc  = 1'b1;
          state_next   = status.idx_last ? ST_FL_LAST : ST_FL_READ;
        end
      end
      ST_FL_LAST: begin
        if (status.out_free) begin
          cmd.load_out   = 1'b1;
          cmd.osel       = OSEL_PEND;
          cmd.flush_done = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: sv/cfs_dp.sv
// ----------------------------------------------------------------------------
// cfs_dp
// Datapath: config registers, field state, hold buffer and output register.
// ----------------------------------------------------------------------------
module cfs_dp #(
  parameter int HOLD_DEPTH = 8,
  localparam int AW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1,
  localparam int CW = $clog2(HOLD_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [cfs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  input  logic                           in_kind,
  input  logic [7:0]                     in_byte,
  input  cfs_pkg::cmd_t                  cmd,
  output cfs_pkg::status_t               status,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [1:0]                     out_kind,
  output logic [7:0]                     out_char,
  output logic [7:0]                     out_field,
  output logic                           out_ovf,
  output logic                           out_last
);
  import cfs_pkg::*;

  logic [7:0]    delimiter_char;
  logic [7:0]    quote_char;
  logic          quoted;
  logic          started;
  logic [CW-1:0] held_count;
  logic [7:0]    field_count;
  logic          ovf_seen;
  logic [CW-1:0] idx;
  logic [7:0]    pend_byte;
  logic [7:0]    held_rdata;
  logic          held_we;
  logic          held_full;
  cls_t          cls;

  // decode, quote wins over delimiter
  always_comb begin
    if (in_kind) begin
      cls = CLS_EOL;
    end else if (in_byte == quote_char) begin
      cls = CLS_QUOTE;
    end else if ((in_byte == delimiter_char) && !quoted) begin
      cls = CLS_DELIM;
    end else if (is_space(in_byte)) begin
      cls = CLS_SPACE;
    end else begin
      cls = CLS_CHAR;
    end
  end

  assign held_full = (held_count == CW'(HOLD_DEPTH));
  assign held_we   = cmd.accept && (cls == CLS_SPACE) && started && !held_full;

  assign status.cls        = cls;
  assign status.held_empty = (held_count == '0);
  assign status.idx_last   = (CW'(idx + CW'(1)) == held_count);
  assign status.out_free   = !out_valid || out_ready;

  cfs_ram #(.WIDTH(8), .DEPTH(HOLD_DEPTH)) u_hold (
    .clk   (clk),
    .we    (held_we),
    .waddr (held_count[AW-1:0]),
    .wdata (in_byte),
    .raddr (idx[AW-1:0]),
    .rdata (held_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter_char <= DELIMITER_RESET;
      quote_char     <= QUOTE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELIMITER: delimiter_char <= cfg_data;
        REG_QUOTE:     quote_char     <= cfg_data;
        default: ;
      endcase
    end
  end

  // field state
  always_ff @(posedge clk) begin
    if (rst) begin
      quoted      <= 1'b0;
      started     <= 1'b0;
      held_count  <= '0;
      field_count <= '0;
      ovf_seen    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        case (cls)
          CLS_EOL: begin
            quoted      <= 1'b0;
            started     <= 1'b0;
            held_count  <= '0;
            field_count <= '0;
            ovf_seen    <= 1'b0;
          end
          CLS_QUOTE: quoted <= !quoted;
          CLS_DELIM: begin
            started    <= 1'b0;
            held_count <= '0;
            ovf_seen   <= 1'b0;
            if (field_count != 8'hFF) begin
              field_count <= field_count + 8'd1;
            end
          end
          CLS_SPACE: begin
            if (started) begin
              if (!held_full) begin
                held_count <= held_count + CW'(1);
              end else begin
                ovf_seen <= 1'b1;
              end
            end
          end
          CLS_CHAR: started <= 1'b1;
          default: ;
        endcase
      end
      if (cmd.flush_done) begin
        held_count <= '0;
      end
    end
  end

  // flush bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_byte <= in_byte;
      idx       <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + CW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_field <= field_count;
      out_ovf   <= ovf_seen;
      out_last  <= cmd.last;
      case (cmd.osel)
        OSEL_EOL: begin
          out_kind <= OK_LINE_END;
          out_char <= 8'd0;
        end
        OSEL_DELIM: begin
          out_kind <= OK_FIELD_END;
          out_char <= 8'd0;
        end
        OSEL_BYTE: begin
          out_kind <= OK_CHAR;
          out_char <= in_byte;
        end
        OSEL_PEND: begin
          out_kind <= OK_CHAR;
          out_char <= pend_byte;
        end
        OSEL_HELD: begin
          out_kind <= OK_CHAR;
          out_char <= held_rdata;
        end
        default: begin
          out_kind <= OK_CHAR;
          out_char <= 8'd0;
        end
      endcase
    end
  end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for csv_field_splitter_unit.
// ----------------------------------------------------------------------------
// A short directed script runs first. It covers empty lines and fields,
// leading and trailing whitespace, quoting, overflow of the hold buffer and
// the byte extremes. Random text lines follow under seven delimiter/quote
// settings, among them equal bytes, zero/all-ones, and whitespace used as a
// delimiter or a quote.
// An in-house predictor keeps its own copy of the splitter state and queues
// the result items that each accepted input item should produce. The output
// monitor compares every result item with the oldest queued one, field by
// field. Both stream sides idle at random, except in the last phase.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cfs_pkg::*;

  localparam int HOLD_DEPTH  = 8;
  localparam int PHASE_ITEMS = 20;                  // minimum random items per setting
  localparam int N_PHASES    = 7;
  localparam int N_ROWS      = 23;
  localparam int LONG_HOLD   = 80;                  // receiver hold-off, cycles
  localparam int SETTLE      = 2 * HOLD_DEPTH + 8;  // worst flush plus margin
  localparam int LIMIT       = 400000;              // cycle budget for the run

  // one result item as seen on the output stream
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [7:0] field;
    logic       ovf;
    logic       last;
  } token_t;

  // directed script row; want is used only where typed is set
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       typed;
    token_t     want;
  } row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DELIMITER;
  logic [7:0]  cfg_data = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic [0:0]  s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  csv_field_splitter_unit #(
    .HOLD_DEPTH(HOLD_DEPTH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // --------------------------------------------------------------------------
  // Predictor state: registers, quoting, held whitespace, field index
  // --------------------------------------------------------------------------
  logic [7:0] delim_reg = DELIMITER_RESET;
  logic [7:0] quote_reg = QUOTE_RESET;
  logic       quoted    = 1'b0;
  logic       started   = 1'b0;
  logic       ovf_seen  = 1'b0;
  logic [7:0] held [HOLD_DEPTH];
  int         held_n    = 0;
  logic [7:0] field_idx = 8'd0;

  token_t     due_tokens [$];   // result items still owed by the block
  int         tokens_made;      // result items caused by the last input item

  // run bookkeeping
  int         errors      = 0;
  int         items_sent  = 0;
  int         tokens_seen = 0;
  int         ovf_tokens  = 0;
  int         top_field   = 0;
  int         cycles      = 0;
  logic       idle_on     = 1'b1;  // random gaps and stalls enabled
  int         hold_stamp  = 0;     // bumped to ask the receiver for a long hold

  function automatic void emit(input logic [1:0] k, input logic [7:0] c);
    token_t t;
    t = '{k, c, field_idx, ovf_seen, 1'b0};
    due_tokens = {due_tokens, t};
    tokens_made++;
  endfunction

  function automatic void close_field();
    started  = 1'b0;
    held_n   = 0;
    ovf_seen = 1'b0;
  endfunction

  // Expected result items for one accepted input item, in decode order:
  // end of line, quote, delimiter outside quotes, whitespace, other byte.
  function automatic void split_byte(input logic k, input logic [7:0] b);
    tokens_made = 0;
    if (k) begin
      emit(OK_LINE_END, 8'h00);
      close_field();
      field_idx = 8'd0;
      quoted    = 1'b0;
    end else if (b == quote_reg) begin
      quoted = !quoted;                 // quote wins when equal to delimiter
    end else if (b == delim_reg && !quoted) begin
      emit(OK_FIELD_END, 8'h00);
      close_field();
      if (field_idx != 8'hFF) field_idx = field_idx + 8'd1;
    end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
      // leading whitespace dropped; trailing held, excess flagged
      if (started) begin
        if (held_n < HOLD_DEPTH) begin
          held[held_n] = b;
          held_n++;
        end else begin
          ovf_seen = 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < held_n; i++) emit(OK_CHAR, held[i]);
      held_n  = 0;
      emit(OK_CHAR, b);
      started = 1'b1;
    end
    if (tokens_made > 0) due_tokens[due_tokens.size()-1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, cycle budget
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Timeout after %0d cycles, %0d items still owed", cycles, due_tokens.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : sink
    int hold_seen;
    int stall;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_stamp != hold_seen) begin
        hold_seen = hold_stamp;
        m_axis_tready <= 1'b0;
        for (int c = 1; c < LONG_HOLD; c++) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 6);
        m_axis_tready <= 1'b0;
        repeat (stall - 1) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor and checker
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 40)
      $display("MISMATCH at result %0d (t=%0t): %s got 0x%0h want 0x%0h",
               tokens_seen, $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : monitor
    token_t got;
    token_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser[1:0], m_axis_tdata[7:0], m_axis_tdata[15:8],
              m_axis_tuser[2], m_axis_tlast};
      tokens_seen++;
      if (got.ovf) ovf_tokens++;
      if (int'(got.field) > top_field) top_field = int'(got.field);
      if (due_tokens.size() == 0) begin
        report_mismatch("result item with nothing owed", int'(got), 0);
      end else begin
        want = due_tokens.pop_front();
        if (got.kind != want.kind)
          report_mismatch("out_kind", int'(got.kind), int'(want.kind));
        if (got.ch != want.ch)
          report_mismatch("char_out", int'(got.ch), int'(want.ch));
        if (got.field != want.field)
          report_mismatch("field_number", int'(got.field), int'(want.field));
        if (got.ovf != want.ovf)
          report_mismatch("ws_overflow", int'(got.ovf), int'(want.ovf));
        if (got.last != want.last)
          report_mismatch("tlast", int'(got.last), int'(want.last));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offer one item, optionally after a gap; returns at the accepting edge
  // with the expected results already queued.
  task automatic send_item(input logic k, input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= k;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    split_byte(k, b);
  endtask

  // Stop offering, let every owed result drain, then let the flush settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (due_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Both registers, back to back; only called while the block is idle.
  task automatic set_regs(input logic [7:0] d, input logic [7:0] q);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DELIMITER;
    cfg_data  <= d;
    @(posedge clk);
    delim_reg = d;
    cfg_index <= REG_QUOTE;
    cfg_data  <= q;
    @(posedge clk);
    quote_reg = q;
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] ws_byte();
    case ($urandom_range(0, 3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  // mostly printable, now and then any byte at all
  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 5) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(33, 126));
  endfunction

  // One text line of random fields; occasionally noise or a missing EOL.
  task automatic send_line();
    int nf;
    int nc;
    int nt;
    nf = $urandom_range(1, 5);
    for (int f = 0; f < nf; f++) begin
      if (f != 0) send_item(1'b0, delim_reg);
      repeat ($urandom_range(0, 2)) send_item(1'b0, ws_byte());
      nc = $urandom_range(0, 6);
      for (int c = 0; c < nc; c++) begin
        case ($urandom_range(0, 9))
          0:       send_item(1'b0, quote_reg);
          1:       send_item(1'b0, delim_reg);   // literal when inside quotes
          2:       send_item(1'b0, ws_byte());
          default: send_item(1'b0, text_byte());
        endcase
      end
      // trailing whitespace, sometimes past the hold depth
      nt = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 11) : $urandom_range(0, 2);
      repeat (nt) send_item(1'b0, ws_byte());
      if ($urandom_range(0, 1) == 0) send_item(1'b0, text_byte());
    end
    if ($urandom_range(0, 7) == 0)
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 9) != 0)
      send_item(1'b1, 8'($urandom_range(0, 255)));   // EOL; byte ignored
  endtask

  // --------------------------------------------------------------------------
  // Directed script, default registers. Rows with a typed result are the
  // obvious single-item cases; the rest go through the predictor.
  // --------------------------------------------------------------------------
  row_t script [N_ROWS] = '{
    // empty line, then an empty field
    '{1'b1, 8'h00,           1'b1, '{OK_LINE_END,  8'h00, 8'd0, 1'b0, 1'b1}},
    '{1'b0, DELIMITER_RESET, 1'b1, '{OK_FIELD_END, 8'h00, 8'd0, 1'b0, 1'b1}},
    // leading space dropped, first character, held tab released by 0xFF
    '{1'b0, CH_SPACE,        1'b0, '0},
    '{1'b0, 8'h61,           1'b1, '{OK_CHAR,      8'h61, 8'd1, 1'b0, 1'b1}},
    '{1'b0, CH_TAB,          1'b0, '0},
    '{1'b0, 8'hFF,           1'b0, '0},
    // quoted: delimiter is literal, whitespace still held
    '{1'b0, QUOTE_RESET,     1'b0, '0},
    '{1'b0, DELIMITER_RESET, 1'b0, '0},
    '{1'b0, CH_SPACE,        1'b0, '0},
    '{1'b0, 8'h62,           1'b0, '0},
    '{1'b0, QUOTE_RESET,     1'b0, '0},
    // nine whitespace bytes: the ninth overflows the hold buffer
    '{1'b0, CH_CR,           1'b0, '0},
    '{1'b0, CH_LF,           1'b0, '0},
    '{1'b0, CH_SPACE,        1'b0, '0},
    '{1'b0, CH_TAB,          1'b0, '0},
    '{1'b0, CH_SPACE,        1'b0, '0},
    '{1'b0, CH_SPACE,        1'b0, '0},
    '{1'b0, CH_SPACE,        1'b0, '0},
    '{1'b0, CH_SPACE,        1'b0, '0},
    '{1'b0, CH_SPACE,        1'b0, '0},
    // zero byte releases all eight held bytes: nine results
    '{1'b0, 8'h00,           1'b0, '0},
    // overflow flag holds until the field ends
    '{1'b0, DELIMITER_RESET, 1'b1, '{OK_FIELD_END, 8'h00, 8'd1, 1'b1, 1'b1}},
    '{1'b1, 8'hFF,           1'b1, '{OK_LINE_END,  8'h00, 8'd2, 1'b0, 1'b1}}
  };

  // delimiter/quote settings: defaults, usual alternatives, extremes,
  // equal bytes (quote wins), whitespace as delimiter and as quote
  logic [7:0] phase_delim [N_PHASES] = '{8'd44, 8'd59, 8'd0,   8'd255, 8'd124, 8'd9,  8'd44};
  logic [7:0] phase_quote [N_PHASES] = '{8'd34, 8'd39, 8'd255, 8'd0,   8'd124, 8'd32, 8'd34};

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int start;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_ROWS; r++) begin
      send_item(script[r].kind, script[r].data);
      if (script[r].typed) begin
        repeat (tokens_made) void'(due_tokens.pop_back());
        due_tokens = {due_tokens, script[r].want};
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      set_regs(phase_delim[p], phase_quote[p]);
      start = items_sent;

      if (p == 0) begin
        // long receiver hold-off while lines keep coming: input must stall
        hold_stamp <= hold_stamp + 1;
        repeat (2) send_line();
        // sender pauses until everything owed has come out
        drain();
        start = items_sent;
      end

      while (items_sent - start < PHASE_ITEMS) begin
        // the last phase runs flat out; elsewhere idling comes and goes
        idle_on <= (p != N_PHASES - 1) && ($urandom_range(0, 4) != 0);
        send_line();
      end
    end

    send_item(1'b1, 8'h00);   // close whatever line is open
    drain();

    $display("Sent %0d input items over %0d delimiter/quote settings; %0d result items checked.",
             items_sent, N_PHASES, tokens_seen);
    $display("Overflow-flagged results: %0d; highest field index seen: %0d; mismatches: %0d.",
             ovf_tokens, top_field, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
